>>> hw/rtl/dhcp_rp_pkg.sv
// Shared constants and types for the DHCP reply parser.
package dhcp_rp_pkg;

	localparam int MAX_PACKET_BYTES = 2048;
	localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);

	localparam logic [OFF_W-1:0] OFF_MAX    = OFF_W'(MAX_PACKET_BYTES);
	localparam logic [OFF_W-1:0] OFF_OPTS   = OFF_W'(240);
	localparam logic [OFF_W-1:0] OFF_COOKIE = OFF_W'(236);
	localparam logic [OFF_W-1:0] OFF_HDR_END = OFF_W'(239);
	localparam logic [OFF_W-1:0] OFF_XID_LO = OFF_W'(4);
	localparam logic [OFF_W-1:0] OFF_XID_HI = OFF_W'(7);
	localparam logic [OFF_W-1:0] OFF_YI_LO  = OFF_W'(16);
	localparam logic [OFF_W-1:0] OFF_YI_HI  = OFF_W'(19);

	localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
	localparam logic [7:0]  BOOTP_REPLY  = 8'h02;

	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_SUBNET   = 8'd1;
	localparam logic [7:0] OPT_ROUTER   = 8'd3;
	localparam logic [7:0] OPT_DNS      = 8'd6;
	localparam logic [7:0] OPT_NTP      = 8'd42;
	localparam logic [7:0] OPT_LEASE    = 8'd51;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_RENEW    = 8'd58;
	localparam logic [7:0] OPT_REBIND   = 8'd59;
	localparam logic [7:0] OPT_END      = 8'hFF;

	localparam logic [7:0] LEN_TYPE = 8'd1;
	localparam logic [7:0] LEN_ADDR = 8'd4;

	localparam logic [7:0] MSG_OFFER = 8'd2;
	localparam logic [7:0] MSG_ACK   = 8'd5;
	localparam logic [7:0] MSG_NAK   = 8'd6;

	typedef enum logic [2:0] {
		ACT_REJECT  = 3'd0,
		ACT_NONE    = 3'd1,
		ACT_REQUEST = 3'd2,
		ACT_APPLY   = 3'd3,
		ACT_RESTART = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		PH_CODE = 3'b001,
		PH_LEN  = 3'b010,
		PH_VAL  = 3'b100
	} phase_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  message_type;
		logic [31:0] offered_ip;
		logic [31:0] server_ip;
		logic [31:0] lease_seconds;
		logic [31:0] renewal_seconds;
		logic [31:0] rebinding_seconds;
		logic [31:0] subnet_mask;
		logic [31:0] router_ip;
		logic [31:0] dns_server_ip;
		logic [31:0] ntp_server_ip;
	} result_t;

endpackage

>>> hw/rtl/dhcp_reply_parser.sv
// DHCP reply parser: header check, option walk and result formatting.
// The result is registered into the result word when the last byte is accepted, or into the skid word while one waits.
// Throughput: one byte per cycle while in_stall is low; the byte walk is a single registered pass.
// A result register plus one skid word let input continue while a result waits;
// in_stall rises only when both hold a word.
// arst_n returns the parse state to idle and clears both result words and the stored transaction ID.
module dhcp_reply_parser
	import dhcp_rp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] transaction_id,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [7:0]  message_type,
	output logic [31:0] offered_ip,
	output logic [31:0] server_ip,
	output logic [31:0] lease_seconds,
	output logic [31:0] renewal_seconds,
	output logic [31:0] rebinding_seconds,
	output logic [31:0] subnet_mask,
	output logic [31:0] router_ip,
	output logic [31:0] dns_server_ip,
	output logic [31:0] ntp_server_ip
);

	logic [31:0]      txid_q;
	logic [OFF_W-1:0] off_q, off_n;
	logic             hg_q, hg_n;
	phase_t           phase_q, phase_n;
	logic             stop_q, stop_n;
	logic [7:0]       code_q, code_n;
	logic [7:0]       len_q, len_n;
	logic [7:0]       rem_q, rem_n;
	logic [31:0]      shift_q, shift_n;
	logic [31:0]      xid_q, xid_n;
	logic [31:0]      yi_q, yi_n;
	logic [31:0]      srv_q, srv_n;
	logic [31:0]      lease_q, lease_n;
	logic [31:0]      renew_q, renew_n;
	logic [31:0]      rebind_q, rebind_n;
	logic [31:0]      subnet_q, subnet_n;
	logic [31:0]      router_q, router_n;
	logic [31:0]      dns_q, dns_n;
	logic [31:0]      ntp_q, ntp_n;
	logic [7:0]       type_q, type_n;
	logic             commit;
	logic             accept;
	logic             done;
	logic [31:0]      lease7;
	result_t          res;
	result_t          out_q, skid_q;
	logic             out_v_q, skid_v_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_v_q;
	assign accept    = in_valid && !in_stall;
	assign done      = accept && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txid_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			txid_q <= transaction_id;
		end
	end

	always_comb begin
		off_n    = off_q;
		hg_n     = hg_q;
		phase_n  = phase_q;
		stop_n   = stop_q;
		code_n   = code_q;
		len_n    = len_q;
		rem_n    = rem_q;
		shift_n  = shift_q;
		xid_n    = xid_q;
		yi_n     = yi_q;
		srv_n    = srv_q;
		lease_n  = lease_q;
		renew_n  = renew_q;
		rebind_n = rebind_q;
		subnet_n = subnet_q;
		router_n = router_q;
		dns_n    = dns_q;
		ntp_n    = ntp_q;
		type_n   = type_q;
		commit   = 1'b0;

		if (off_q < OFF_OPTS) begin
			if (off_q == '0 && data_byte != BOOTP_REPLY) begin
				hg_n = 1'b0;
			end
			if (off_q inside {[OFF_XID_LO:OFF_XID_HI]}) begin
				xid_n = {xid_q[23:0], data_byte};
				if (off_q == OFF_XID_HI && xid_n != txid_q) begin
					hg_n = 1'b0;
				end
			end
			if (off_q inside {[OFF_YI_LO:OFF_YI_HI]}) begin
				yi_n = {yi_q[23:0], data_byte};
			end
			if (off_q >= OFF_COOKIE) begin
				shift_n = {shift_q[23:0], data_byte};
				if (off_q == OFF_HDR_END && shift_n != MAGIC_COOKIE) begin
					hg_n = 1'b0;
				end
			end
		end else if (!stop_q) begin
			if (off_q >= OFF_MAX) begin
				stop_n = 1'b1;
			end else begin
				case (phase_q)
					PH_CODE: begin
						if (data_byte == OPT_END) begin
							stop_n = 1'b1;
						end else if (data_byte != OPT_PAD) begin
							code_n  = data_byte;
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						len_n   = data_byte;
						shift_n = '0;
						if (data_byte == 8'd0) begin
							phase_n = PH_CODE;
						end else begin
							rem_n   = data_byte;
							phase_n = PH_VAL;
						end
					end
					PH_VAL: begin
						shift_n = {shift_q[23:0], data_byte};
						rem_n   = rem_q - 8'd1;
						if (rem_n == 8'd0) begin
							phase_n = PH_CODE;
							commit  = 1'b1;
						end
					end
					default: begin
						phase_n = PH_CODE;
					end
				endcase
			end
		end

		if (commit) begin
			if (code_q == OPT_MSG_TYPE) begin
				if (len_q == LEN_TYPE) begin
					type_n = shift_n[7:0];
				end
			end else if (len_q == LEN_ADDR) begin
				case (code_q)
					OPT_SUBNET: subnet_n = shift_n;
					OPT_ROUTER: router_n = shift_n;
					OPT_DNS:    dns_n    = shift_n;
					OPT_NTP:    ntp_n    = shift_n;
					OPT_LEASE:  lease_n  = shift_n;
					OPT_SERVER: srv_n    = shift_n;
					OPT_RENEW:  renew_n  = shift_n;
					OPT_REBIND: rebind_n = shift_n;
					default: ;
				endcase
			end
		end

		if (off_q < OFF_MAX) begin
			off_n = off_q + OFF_W'(1);
		end
	end

	// lease * 7 mod 2^32
	assign lease7 = {lease_n[28:0], 3'b000} - lease_n;

	always_comb begin
		res = '0;
		if (hg_n && off_q >= OFF_HDR_END) begin
			res.action = ACT_NONE;
			if (type_n == MSG_OFFER) begin
				if (yi_n != '0 && srv_n != '0) begin
					res.action = ACT_REQUEST;
				end
			end else if (type_n == MSG_ACK) begin
				res.action = ACT_APPLY;
			end else if (type_n == MSG_NAK) begin
				res.action = ACT_RESTART;
			end
			res.message_type      = type_n;
			res.offered_ip        = yi_n;
			res.server_ip         = srv_n;
			res.lease_seconds     = lease_n;
			res.renewal_seconds   = (renew_n != '0) ? renew_n : {1'b0, lease_n[31:1]};
			res.rebinding_seconds = (rebind_n != '0) ? rebind_n : {3'b000, lease7[31:3]};
			res.subnet_mask       = subnet_n;
			res.router_ip         = router_n;
			res.dns_server_ip     = dns_n;
			res.ntp_server_ip     = ntp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			hg_q     <= 1'b1;
			phase_q  <= PH_CODE;
			stop_q   <= 1'b0;
			code_q   <= '0;
			len_q    <= '0;
			rem_q    <= '0;
			shift_q  <= '0;
			xid_q    <= '0;
			yi_q     <= '0;
			srv_q    <= '0;
			lease_q  <= '0;
			renew_q  <= '0;
			rebind_q <= '0;
			subnet_q <= '0;
			router_q <= '0;
			dns_q    <= '0;
			ntp_q    <= '0;
			type_q   <= '0;
		end else if (done) begin
			off_q    <= '0;
			hg_q     <= 1'b1;
			phase_q  <= PH_CODE;
			stop_q   <= 1'b0;
			code_q   <= '0;
			len_q    <= '0;
			rem_q    <= '0;
			shift_q  <= '0;
			xid_q    <= '0;
			yi_q     <= '0;
			srv_q    <= '0;
			lease_q  <= '0;
			renew_q  <= '0;
			rebind_q <= '0;
			subnet_q <= '0;
			router_q <= '0;
			dns_q    <= '0;
			ntp_q    <= '0;
			type_q   <= '0;
		end else if (accept) begin
			off_q    <= off_n;
			hg_q     <= hg_n;
			phase_q  <= phase_n;
			stop_q   <= stop_n;
			code_q   <= code_n;
			len_q    <= len_n;
			rem_q    <= rem_n;
			shift_q  <= shift_n;
			xid_q    <= xid_n;
			yi_q     <= yi_n;
			srv_q    <= srv_n;
			lease_q  <= lease_n;
			renew_q  <= renew_n;
			rebind_q <= rebind_n;
			subnet_q <= subnet_n;
			router_q <= router_n;
			dns_q    <= dns_n;
			ntp_q    <= ntp_n;
			type_q   <= type_n;
		end
	end

	// result word and skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
			out_q    <= '0;
			skid_q   <= '0;
		end else begin
			if (out_v_q && !out_stall) begin
				if (skid_v_q) begin
					out_q    <= skid_q;
					skid_v_q <= 1'b0;
				end else if (done) begin
					out_q <= res;
				end else begin
					out_v_q <= 1'b0;
				end
			end else if (done) begin
				if (out_v_q) begin
					skid_q   <= res;
					skid_v_q <= 1'b1;
				end else begin
					out_q   <= res;
					out_v_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid         = out_v_q;
	assign action            = out_q.action;
	assign message_type      = out_q.message_type;
	assign offered_ip        = out_q.offered_ip;
	assign server_ip         = out_q.server_ip;
	assign lease_seconds     = out_q.lease_seconds;
	assign renewal_seconds   = out_q.renewal_seconds;
	assign rebinding_seconds = out_q.rebinding_seconds;
	assign subnet_mask       = out_q.subnet_mask;
	assign router_ip         = out_q.router_ip;
	assign dns_server_ip     = out_q.dns_server_ip;
	assign ntp_server_ip     = out_q.ntp_server_ip;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held without a result word");

	a_off_sat: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= OFF_MAX)
		else $error("byte offset past saturation");

	a_no_stop_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= OFF_OPTS |-> !stop_q && phase_q == PH_CODE)
		else $error("option walk active inside header");

	a_val_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VAL |-> rem_q != 8'd0)
		else $error("value phase with nothing remaining");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.action == ACT_REJECT |->
			out_q.message_type == '0 && out_q.offered_ip == '0 && out_q.lease_seconds == '0)
		else $error("rejected word carries data");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for dhcp_reply_parser: directed and random packets checked per reply.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dhcp_rp_pkg::*;

	localparam int LIMIT = 2_000_000;
	localparam int RANDOM_PACKETS = 45;
	localparam logic [7:0] OPT_VENDOR = 8'd200;
	localparam logic [7:0] OPT_OTHER = 8'd201;
	localparam logic [7:0] KEPT [8] = '{OPT_SUBNET, OPT_ROUTER, OPT_DNS, OPT_NTP,
		OPT_LEASE, OPT_SERVER, OPT_RENEW, OPT_REBIND};

	typedef enum {
		OS_NONE, OS_ACK_FULL, OS_OFFER, OS_OFFER_NOSRV, OS_NAK, OS_PAD_END, OS_BAD_SIZE,
		OS_REPEAT, OS_TIMERS, OS_TIMERS_ZERO, OS_TRUNC_LEN, OS_TRUNC_VAL, OS_LONG_UNKNOWN,
		OS_OVERSIZE
	} opt_set_t;

	typedef struct {
		logic        wr;
		logic [31:0] xid;
		logic [7:0]  opcode;
		logic        xid_bad;
		logic [31:0] yiaddr;
		logic        cookie_bad;
		int          cut;
		opt_set_t    opts;
		logic        typed;
		action_t     act;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] transaction_id;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [7:0]  message_type;
	logic [31:0] offered_ip;
	logic [31:0] server_ip;
	logic [31:0] lease_seconds;
	logic [31:0] renewal_seconds;
	logic [31:0] rebinding_seconds;
	logic [31:0] subnet_mask;
	logic [31:0] router_ip;
	logic [31:0] dns_server_ip;
	logic [31:0] ntp_server_ip;

	dhcp_reply_parser i_dut (.*);

	always #5ns clk = ~clk;

	// parser shadow state
	logic [31:0]      xid_cfg;
	logic [OFF_W-1:0] p_off;
	logic             p_hdr_ok;
	phase_t           p_phase;
	logic             p_done;
	logic [7:0]       p_code, p_len, p_left, p_type;
	logic [31:0]      p_acc, p_xid, p_yi;
	logic [31:0]      p_opt [256];

	result_t    reply_q [$];
	logic [7:0] pkt [$];
	dir_row_t   rows [$];

	int      err_cnt, n_bytes, n_pkts, n_checked, stall_left, rand_pkts;
	int      act_seen [5];
	bit      quiet_in, quiet_out, cur_typed;
	result_t cur_want;

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic void parse_clear();
		p_off = '0;
		p_hdr_ok = 1'b1;
		p_phase = PH_CODE;
		p_done = 1'b0;
		p_code = '0;
		p_len = '0;
		p_left = '0;
		p_type = '0;
		p_acc = '0;
		p_xid = '0;
		p_yi = '0;
		foreach (p_opt[i])
			p_opt[i] = '0;
	endfunction

	function automatic void opt_commit();
		if (p_code == OPT_MSG_TYPE) begin
			if (p_len == LEN_TYPE)
				p_type = p_acc[7:0];
		end else if (p_len == LEN_ADDR) begin
			case (p_code)
				OPT_SUBNET, OPT_ROUTER, OPT_DNS, OPT_NTP,
				OPT_LEASE, OPT_SERVER, OPT_RENEW, OPT_REBIND: p_opt[p_code] = p_acc;
				default: ;
			endcase
		end
	endfunction

	function automatic void opt_walk(logic [7:0] b);
		case (p_phase)
			PH_CODE: begin
				if (b == OPT_END)
					p_done = 1'b1;
				else if (b != OPT_PAD) begin
					p_code = b;
					p_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				p_len = b;
				p_acc = '0;
				if (b == 8'd0) begin
					opt_commit();
					p_phase = PH_CODE;
				end else begin
					p_left = b;
					p_phase = PH_VAL;
				end
			end
			default: begin
				p_acc = {p_acc[23:0], b};
				p_left = p_left - 8'd1;
				if (p_left == 8'd0) begin
					opt_commit();
					p_phase = PH_CODE;
				end
			end
		endcase
	endfunction

	// one accepted byte; returns 1 with the reply when the byte ends the packet
	function automatic bit parse_byte(input logic [7:0] b, input logic l, output result_t r);
		logic [OFF_W-1:0] off;
		logic [31:0]      lease, l7;
		off = p_off;
		r = '0;
		if (off < OFF_OPTS) begin
			if (off == '0 && b != BOOTP_REPLY)
				p_hdr_ok = 1'b0;
			if (off >= OFF_XID_LO && off <= OFF_XID_HI) begin
				p_xid = {p_xid[23:0], b};
				if (off == OFF_XID_HI && p_xid != xid_cfg)
					p_hdr_ok = 1'b0;
			end
			if (off >= OFF_YI_LO && off <= OFF_YI_HI)
				p_yi = {p_yi[23:0], b};
			if (off >= OFF_COOKIE) begin
				p_acc = {p_acc[23:0], b};
				if (off == OFF_HDR_END && p_acc != MAGIC_COOKIE)
					p_hdr_ok = 1'b0;
			end
		end else if (!p_done) begin
			if (off >= OFF_MAX)
				p_done = 1'b1;
			else
				opt_walk(b);
		end
		if (off < OFF_MAX)
			p_off = off + OFF_W'(1);
		if (!l)
			return 1'b0;
		if (p_hdr_ok && off >= OFF_HDR_END) begin
			lease = p_opt[OPT_LEASE];
			l7 = lease * 32'd7;
			r.action = ACT_NONE;
			case (p_type)
				MSG_OFFER: if (p_yi != '0 && p_opt[OPT_SERVER] != '0) r.action = ACT_REQUEST;
				MSG_ACK:   r.action = ACT_APPLY;
				MSG_NAK:   r.action = ACT_RESTART;
				default: ;
			endcase
			r.message_type = p_type;
			r.offered_ip = p_yi;
			r.server_ip = p_opt[OPT_SERVER];
			r.lease_seconds = lease;
			r.renewal_seconds = (p_opt[OPT_RENEW] != '0) ? p_opt[OPT_RENEW] : lease >> 1;
			r.rebinding_seconds = (p_opt[OPT_REBIND] != '0) ? p_opt[OPT_REBIND] : l7 >> 3;
			r.subnet_mask = p_opt[OPT_SUBNET];
			r.router_ip = p_opt[OPT_ROUTER];
			r.dns_server_ip = p_opt[OPT_DNS];
			r.ntp_server_ip = p_opt[OPT_NTP];
		end
		parse_clear();
		return 1'b1;
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_in || r < 75)
			return 0;
		return (r < 95) ? $urandom_range(1, 3) : $urandom_range(6, 25);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 3))
			0: return MSG_OFFER;
			1: return MSG_ACK;
			2: return MSG_NAK;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void put(logic [7:0] b);
		pkt.push_back(b);
	endfunction

	function automatic void add_opt(logic [7:0] code, logic [7:0] len, logic [31:0] val);
		put(code);
		put(len);
		for (int i = 0; i < len; i++) begin
			if (len == LEN_ADDR)
				put(val[31-8*i -: 8]);
			else if (len == LEN_TYPE)
				put(val[7:0]);
			else
				put(8'($urandom));
		end
	endfunction

	function automatic void cut_to(int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
		while (pkt.size() < n)
			put(8'($urandom));
	endfunction

	function automatic void put_header(logic [7:0] op, logic [31:0] xid, logic [31:0] yi,
			logic [31:0] cookie);
		pkt.delete();
		for (int i = 0; i < 240; i++) begin
			if (i == 0)
				put(op);
			else if (i >= 4 && i <= 7)
				put(xid[31-8*(i-4) -: 8]);
			else if (i >= 16 && i <= 19)
				put(yi[31-8*(i-16) -: 8]);
			else if (i >= 236)
				put(cookie[31-8*(i-236) -: 8]);
			else
				put(8'($urandom));
		end
	endfunction

	function automatic void put_opts(opt_set_t os);
		case (os)
			OS_ACK_FULL: begin
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				add_opt(OPT_SUBNET, LEN_ADDR, 32'hFFFF_FF00);
				add_opt(OPT_ROUTER, LEN_ADDR, 32'h0A00_0001);
				add_opt(OPT_DNS, LEN_ADDR, 32'h0808_0808);
				add_opt(OPT_NTP, LEN_ADDR, 32'h0A00_0002);
				add_opt(OPT_LEASE, LEN_ADDR, 32'hFFFF_FFFF);
				add_opt(OPT_SERVER, LEN_ADDR, 32'h0A00_00FE);
			end
			OS_OFFER, OS_OFFER_NOSRV: begin
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_OFFER);
				if (os == OS_OFFER)
					add_opt(OPT_SERVER, LEN_ADDR, 32'hC0A8_0001);
				add_opt(OPT_LEASE, LEN_ADDR, 32'd3600);
			end
			OS_NAK: begin
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_NAK);
				add_opt(OPT_SERVER, LEN_ADDR, 32'hC0A8_0001);
			end
			OS_PAD_END: begin
				put(OPT_PAD);
				put(OPT_PAD);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				put(OPT_PAD);
				add_opt(OPT_LEASE, LEN_ADDR, 32'd7200);
				put(OPT_END);
				add_opt(OPT_SUBNET, LEN_ADDR, 32'hFFFF_0000);
				put(8'($urandom));
			end
			OS_BAD_SIZE: begin
				add_opt(OPT_SUBNET, 8'd3, '0);
				add_opt(OPT_MSG_TYPE, 8'd2, '0);
				add_opt(OPT_MSG_TYPE, 8'd0, '0);
				add_opt(OPT_OTHER, 8'd0, '0);
				add_opt(OPT_ROUTER, 8'd5, '0);
				add_opt(OPT_SERVER, LEN_ADDR, 32'h0102_0304);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
			end
			OS_REPEAT: begin
				add_opt(OPT_LEASE, LEN_ADDR, 32'd100);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_OFFER);
				add_opt(OPT_LEASE, LEN_ADDR, 32'd200);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				add_opt(OPT_DNS, LEN_ADDR, 32'd1);
				add_opt(OPT_DNS, LEN_ADDR, 32'd2);
			end
			OS_TIMERS, OS_TIMERS_ZERO: begin
				add_opt(OPT_LEASE, LEN_ADDR, (os == OS_TIMERS) ? 32'd1000 : 32'd1001);
				add_opt(OPT_RENEW, LEN_ADDR, (os == OS_TIMERS) ? 32'd300 : 32'd0);
				add_opt(OPT_REBIND, LEN_ADDR, (os == OS_TIMERS) ? 32'd700 : 32'd0);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
			end
			OS_TRUNC_LEN: begin
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				add_opt(OPT_LEASE, LEN_ADDR, 32'd50);
				put(OPT_SUBNET);
			end
			OS_TRUNC_VAL: begin
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				put(OPT_DNS);
				put(LEN_ADDR);
				put(8'($urandom));
				put(8'($urandom));
			end
			OS_LONG_UNKNOWN: begin
				add_opt(OPT_VENDOR, 8'd255, '0);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				add_opt(OPT_NTP, LEN_ADDR, 32'h8000_0000);
			end
			OS_OVERSIZE: begin
				// the second lease option straddles the offset cap and is dropped
				add_opt(OPT_LEASE, LEN_ADDR, 32'd500);
				add_opt(OPT_MSG_TYPE, LEN_TYPE, MSG_ACK);
				repeat (6) add_opt(OPT_VENDOR, 8'd255, '0);
				add_opt(OPT_OTHER, 8'd251, '0);
				add_opt(OPT_LEASE, LEN_ADDR, 32'h1111_1111);
			end
			default: ;
		endcase
	endfunction

	function automatic void rand_option();
		case ($urandom_range(0, 9))
			0: put(OPT_PAD);
			1: add_opt(OPT_MSG_TYPE, LEN_TYPE, pick_type());
			2, 3, 4, 5, 6: add_opt(KEPT[$urandom_range(0, 7)], LEN_ADDR, rand_word());
			7: add_opt(KEPT[$urandom_range(0, 7)], 8'($urandom_range(0, 8)), rand_word());
			8: add_opt(OPT_MSG_TYPE, 8'($urandom_range(0, 3)), pick_type());
			default: add_opt(8'($urandom_range(1, 254)), 8'($urandom_range(0, 12)), rand_word());
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b, logic l);
		result_t r;
		int      gap;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		n_bytes++;
		if (parse_byte(b, l, r)) begin
			if (cur_typed)
				r = cur_want;
			reply_q.push_back(r);
			act_seen[r.action]++;
			n_pkts++;
		end
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			last_byte <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_packet();
		quiet_in = ($urandom_range(0, 3) == 0);
		quiet_out = ($urandom_range(0, 3) == 0);
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_xid(logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		transaction_id <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		xid_cfg = v;
	endtask

	task automatic random_packet();
		int          r, avail;
		logic [7:0]  op;
		logic [31:0] xid, ck;
		r = $urandom_range(0, 99);
		op = (r < 6) ? 8'($urandom_range(0, 255)) : BOOTP_REPLY;
		xid = (r >= 6 && r < 12) ? xid_cfg ^ (32'd1 << $urandom_range(0, 31)) : xid_cfg;
		ck = (r >= 12 && r < 16) ? MAGIC_COOKIE ^ (32'd1 << $urandom_range(0, 31))
			: MAGIC_COOKIE;
		put_header(op, xid, rand_word(), ck);
		if ($urandom_range(0, 9) < 7)
			add_opt(OPT_MSG_TYPE, LEN_TYPE, pick_type());
		if ($urandom_range(0, 1) == 1)
			add_opt(OPT_SERVER, LEN_ADDR, rand_word());
		repeat ($urandom_range(0, 8)) rand_option();
		avail = pkt.size() - 240;
		case ($urandom_range(0, 9))
			0: begin
				put(OPT_END);
				repeat ($urandom_range(0, 6)) put(8'($urandom));
			end
			1: if (avail > 0) cut_to(pkt.size() - $urandom_range(1, (avail < 3) ? avail : 3));
			default: ;
		endcase
		if (r >= 16 && r < 24)
			cut_to($urandom_range(1, 239));
		else if (r == 24)
			cut_to($urandom_range(2049, 2080));
		send_packet();
	endtask

	function automatic dir_row_t mk(int wr, logic [31:0] xid, logic [7:0] op, int xbad,
			logic [31:0] yi, int cbad, int cut, opt_set_t os, int typed, action_t act);
		return '{1'(wr), xid, op, 1'(xbad), yi, 1'(cbad), cut, os, 1'(typed), act};
	endfunction

	task automatic cur_check(result_t want);
		n_checked++;
		cmp_field("action", 32'(action), 32'(want.action));
		cmp_field("message_type", 32'(message_type), 32'(want.message_type));
		cmp_field("offered_ip", offered_ip, want.offered_ip);
		cmp_field("server_ip", server_ip, want.server_ip);
		cmp_field("lease_seconds", lease_seconds, want.lease_seconds);
		cmp_field("renewal_seconds", renewal_seconds, want.renewal_seconds);
		cmp_field("rebinding_seconds", rebinding_seconds, want.rebinding_seconds);
		cmp_field("subnet_mask", subnet_mask, want.subnet_mask);
		cmp_field("router_ip", router_ip, want.router_ip);
		cmp_field("dns_server_ip", dns_server_ip, want.dns_server_ip);
		cmp_field("ntp_server_ip", ntp_server_ip, want.ntp_server_ip);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0)
				report("reply with nothing pending");
			else begin
				cur_check(reply_q.pop_front());
			end
		end
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
		else if (!quiet_out && $urandom_range(0, 7) == 0)
			stall_left = pick_len();
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("timeout with %0d replies pending", reply_q.size());
		$display("testbench: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		transaction_id = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		xid_cfg = '0;
		cur_typed = 1'b0;
		parse_clear();

		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'h0A00_0064, 0, 0, OS_NONE, 1, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'h0A00_0065, 0, 0, OS_ACK_FULL, 0, ACT_NONE));
		rows.push_back(mk(1, 32'hFFFF_FFFF, 8'h01, 0, 32'h0A00_0066, 0, 0, OS_ACK_FULL, 1,
			ACT_REJECT));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 1, 32'h0A00_0067, 0, 0, OS_ACK_FULL, 1, ACT_REJECT));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'h0A00_0068, 1, 0, OS_ACK_FULL, 1, ACT_REJECT));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'h0A00_0069, 0, 1, OS_NONE, 1, ACT_REJECT));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'h0A00_006A, 0, 239, OS_NONE, 1, ACT_REJECT));
		rows.push_back(mk(0, 0, 8'hFF, 0, 32'h0A00_006B, 0, 0, OS_NONE, 1, ACT_REJECT));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_0064, 0, 0, OS_OFFER, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'h0, 0, 0, OS_OFFER, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_0065, 0, 0, OS_OFFER_NOSRV, 0,
			ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_0066, 0, 0, OS_NAK, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_0067, 0, 0, OS_PAD_END, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_0068, 0, 0, OS_BAD_SIZE, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_0069, 0, 0, OS_REPEAT, 0, ACT_NONE));
		rows.push_back(mk(1, 32'h8000_0001, BOOTP_REPLY, 0, 32'hC0A8_006A, 0, 0, OS_TIMERS, 0,
			ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_006B, 0, 0, OS_TIMERS_ZERO, 0,
			ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_006C, 0, 0, OS_TRUNC_LEN, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_006D, 0, 0, OS_TRUNC_VAL, 0, ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_006E, 0, 0, OS_LONG_UNKNOWN, 0,
			ACT_NONE));
		rows.push_back(mk(0, 0, BOOTP_REPLY, 0, 32'hC0A8_006F, 0, 2100, OS_OVERSIZE, 0,
			ACT_NONE));
		rows.push_back(mk(1, 32'h0, BOOTP_REPLY, 0, 32'hFFFF_FFFF, 0, 0, OS_ACK_FULL, 0,
			ACT_NONE));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].wr)
				write_xid(rows[i].xid);
			put_header(rows[i].opcode, rows[i].xid_bad ? xid_cfg ^ 32'h0000_0100 : xid_cfg,
				rows[i].yiaddr, rows[i].cookie_bad ? MAGIC_COOKIE ^ 32'h0100_0000
				: MAGIC_COOKIE);
			put_opts(rows[i].opts);
			if (rows[i].cut > 0)
				cut_to(rows[i].cut);
			cur_typed = rows[i].typed;
			cur_want = '0;
			if (rows[i].act != ACT_REJECT) begin
				cur_want.action = rows[i].act;
				cur_want.offered_ip = rows[i].yiaddr;
			end
			send_packet();
		end
		cur_typed = 1'b0;

		rand_pkts = 0;
		while (rand_pkts < RANDOM_PACKETS) begin
			if (rand_pkts % 10 == 5) begin
				case ($urandom_range(0, 2))
					0: write_xid(32'h0);
					1: write_xid(32'hFFFF_FFFF);
					default: write_xid($urandom);
				endcase
			end else if ($urandom_range(0, 7) == 0)
				drain();
			random_packet();
			rand_pkts++;
		end

		drain();
		repeat (5) @(posedge clk);
		if (reply_q.size() != 0)
			report($sformatf("%0d replies never arrived", reply_q.size()));
		$display("covered %0d packets, %0d bytes, %0d replies compared", n_pkts, n_bytes,
			n_checked);
		$display("actions: reject %0d, none %0d, request %0d, apply %0d, restart %0d",
			act_seen[ACT_REJECT], act_seen[ACT_NONE], act_seen[ACT_REQUEST],
			act_seen[ACT_APPLY], act_seen[ACT_RESTART]);
		if (err_cnt == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
